### rtl/vertex_rotate_project_viewport_top_macros.svh
// Assertion helpers for the vertex transform block.
// Both macros compile away when SYNTHESIS is defined.
`ifndef VERTEX_ROTATE_PROJECT_VIEWPORT_TOP_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_VIEWPORT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define VRPV_ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vrpv assertion failed");
`define VRPV_ASSERT(lbl, prop) `VRPV_ASSERT_AT(lbl, clk_i, rst_ni, prop)
`else
`define VRPV_ASSERT_AT(lbl, clk, rstn, prop)
`define VRPV_ASSERT(lbl, prop)
`endif

`endif

### rtl/vrpv_pkg.sv
`default_nettype none

package vrpv_pkg;

  localparam int COEF_W     = 16;  // register and coordinate width
  localparam int SIZE_W     = 11;  // viewport size width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TRIG_FRAC  = 14;  // Q2.14 sine/cosine
  localparam int PROJ_FRAC  = 12;  // Q4.12 projection scale
  localparam int DEN_W      = 23;  // w and divisor d, signed
  localparam int NUMP_W     = 40;  // p + d*2^12, signed
  localparam int NUM_W      = 52;  // (p + d*2^12) * size, signed
  localparam int DIVD_W     = NUM_W - PROJ_FRAC - 1;  // |num| >> 13
  localparam int Q_W        = 12;  // quotient bits before saturation
  localparam int PIX_W      = 12;

  localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(2047);
  localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-2048);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_Z         = 3'd0,
    REG_SIN_Z         = 3'd1,
    REG_COS_X         = 3'd2,
    REG_SIN_X         = 3'd3,
    REG_PROJ_X_SCALE  = 3'd4,
    REG_PROJ_Y_SCALE  = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_z;
    logic signed [COEF_W-1:0] sin_z;
    logic signed [COEF_W-1:0] cos_x;
    logic signed [COEF_W-1:0] sin_x;
    logic        [COEF_W-1:0] proj_x_scale;
    logic        [COEF_W-1:0] proj_y_scale;
    logic        [SIZE_W-1:0] screen_width;
    logic        [SIZE_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] vertex_x;
    logic signed [COEF_W-1:0] vertex_y;
    logic signed [COEF_W-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] screen_x;
    logic signed [PIX_W-1:0] screen_y;
    logic                    w_was_zero;
  } pixel_t;

  // transform front end to divider
  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DEN_W-1:0] d;
    logic                    wz;
  } xf_t;

endpackage

`default_nettype wire

### rtl/vrpv_stream_if.sv
`default_nettype none

interface vrpv_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/vrpv_pipe_ctl.sv
`default_nettype none
`include "vertex_rotate_project_viewport_top_macros.svh"

module vrpv_pipe_ctl #(
  parameter int STAGES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic [STAGES-1:0] ld_o,
  output logic [STAGES-1:0] valid_o
);

  logic [STAGES-1:0] v_q, v_d, ld;

  // a stage loads when any stage at or after it is empty, or the sink takes
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      ld[k] = out_ready_i || !(&(v_q | ((STAGES'(1) << k) - STAGES'(1))));
    end
  end

  always_comb begin
    v_d[0] = ld[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < STAGES; k++) begin
      v_d[k] = ld[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = ld[0];
  assign ld_o       = ld;
  assign valid_o    = v_q;

  `VRPV_ASSERT(a_bubble_ready, !(&v_q) |-> in_ready_o)
  `VRPV_ASSERT(a_full_stall, (&v_q && !out_ready_i) |-> !in_ready_o)
  `VRPV_ASSERT(a_accept_fills, (in_valid_i && in_ready_o) |=> v_q[0])
  `VRPV_ASSERT(a_beat_count, 1'b1 |=> $countones(v_q) == $countones($past(v_q))
    + int'($past(in_valid_i && in_ready_o)) - int'($past(v_q[STAGES-1] && out_ready_i)))

endmodule

`default_nettype wire

### rtl/vrpv_xform.sv
`default_nettype none

module vrpv_xform
  import vrpv_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  vertex_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output xf_t     out_data_o
);

  localparam int STAGES = 7;
  localparam logic signed [DEN_W-1:0] W_OFS = DEN_W'(3 << COORD_FRAC_BITS);
  localparam logic signed [DEN_W-1:0] D_ONE = DEN_W'(1 << COORD_FRAC_BITS);
  localparam logic signed [32:0] RND_A = 33'(1 << (TRIG_FRAC - 1));
  localparam logic signed [35:0] RND_B = 36'(1 << (TRIG_FRAC - 1));

  logic [STAGES-1:0] ld, vld;

  vrpv_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_ready_i,
    .ld_o    (ld),
    .valid_o (vld)
  );

  assign out_valid_o = vld[STAGES-1];

  // s1: Z rotation products
  logic signed [31:0]       xc_q, ys_q, xs_q, yc_q;
  logic signed [COEF_W-1:0] z1_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      xc_q <= in_data_i.vertex_x * cfg_i.cos_z;
      ys_q <= in_data_i.vertex_y * cfg_i.sin_z;
      xs_q <= in_data_i.vertex_x * cfg_i.sin_z;
      yc_q <= in_data_i.vertex_y * cfg_i.cos_z;
      z1_q <= in_data_i.vertex_z;
    end
  end

  // s2: round half up to coordinate format
  logic signed [32:0]       sx1, sy1;
  logic signed [18:0]       x1_q, y1_q;
  logic signed [COEF_W-1:0] z2_q;

  always_comb begin
    sx1 = 33'(xc_q) - 33'(ys_q) + RND_A;
    sy1 = 33'(xs_q) + 33'(yc_q) + RND_A;
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      x1_q <= sx1[32:TRIG_FRAC];
      y1_q <= sy1[32:TRIG_FRAC];
      z2_q <= z1_q;
    end
  end

  // s3: X rotation products
  logic signed [34:0] yc3_q, ys3_q;
  logic signed [31:0] zs3_q, zc3_q;
  logic signed [18:0] x3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      yc3_q <= y1_q * cfg_i.cos_x;
      ys3_q <= y1_q * cfg_i.sin_x;
      zs3_q <= z2_q * cfg_i.sin_x;
      zc3_q <= z2_q * cfg_i.cos_x;
      x3_q  <= x1_q;
    end
  end

  // s4: round, push into the screen, flag w == 0
  logic signed [35:0]      sy2, sz2;
  logic signed [21:0]      y2, z2;
  logic signed [DEN_W-1:0] w;
  logic                    wz;
  logic signed [21:0]      y4_q;
  logic signed [18:0]      x4_q;
  logic signed [DEN_W-1:0] d4_q;
  logic                    wz4_q;

  always_comb begin
    sy2 = 36'(yc3_q) - 36'(zs3_q) + RND_B;
    sz2 = 36'(ys3_q) + 36'(zc3_q) + RND_B;
    y2  = sy2[35:TRIG_FRAC];
    z2  = sz2[35:TRIG_FRAC];
    w   = DEN_W'(z2) + W_OFS;
    wz  = (w == '0);
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      x4_q  <= x3_q;
      y4_q  <= y2;
      d4_q  <= wz ? D_ONE : w;
      wz4_q <= wz;
    end
  end

  // s5: projection scale
  logic signed [35:0]      px_q;
  logic signed [38:0]      py_q;
  logic signed [DEN_W-1:0] d5_q;
  logic                    wz5_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      px_q  <= x4_q * $signed({1'b0, cfg_i.proj_x_scale});
      py_q  <= y4_q * $signed({1'b0, cfg_i.proj_y_scale});
      d5_q  <= d4_q;
      wz5_q <= wz4_q;
    end
  end

  // s6: add one in clip space (d * 2^12)
  logic signed [NUMP_W-1:0] sx6_q, sy6_q;
  logic signed [DEN_W-1:0]  d6_q;
  logic                     wz6_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      sx6_q <= NUMP_W'(px_q) + (NUMP_W'(d5_q) <<< PROJ_FRAC);
      sy6_q <= NUMP_W'(py_q) + (NUMP_W'(d5_q) <<< PROJ_FRAC);
      d6_q  <= d5_q;
      wz6_q <= wz5_q;
    end
  end

  // s7: scale by viewport size
  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      out_data_o.num_x <= sx6_q * $signed({1'b0, cfg_i.screen_width});
      out_data_o.num_y <= sy6_q * $signed({1'b0, cfg_i.screen_height});
      out_data_o.d     <= d6_q;
      out_data_o.wz    <= wz6_q;
    end
  end

endmodule

`default_nettype wire

### rtl/vrpv_div.sv
`default_nettype none

module vrpv_div
  import vrpv_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  xf_t    in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output pixel_t out_data_o
);

  localparam int LANES  = 2;
  localparam int STAGES = Q_W + 3;  // magnitude, range check, one per bit, saturate

  logic [STAGES-1:0] ld, vld;

  vrpv_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_ready_i,
    .ld_o    (ld),
    .valid_o (vld)
  );

  assign out_valid_o = vld[STAGES-1];

  // stage 0: magnitudes; den has 13 zero low bits, folded into the dividend
  logic signed [NUM_W-1:0] num [LANES];
  logic        [NUM_W-1:0] mag [LANES];
  logic        [DEN_W-1:0] dmag;

  assign num[0] = in_data_i.num_x;
  assign num[1] = in_data_i.num_y;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
    end
    dmag = in_data_i.d[DEN_W-1] ? DEN_W'(-in_data_i.d) : DEN_W'(in_data_i.d);
  end

  logic [DIVD_W-1:0] a0_q [LANES];
  logic [LANES-1:0]  neg0_q;
  logic [DEN_W-1:0]  b0_q;
  logic              wz0_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      for (int l = 0; l < LANES; l++) begin
        a0_q[l]   <= mag[l][NUM_W-1 -: DIVD_W];
        neg0_q[l] <= num[l][NUM_W-1] ^ in_data_i.d[DEN_W-1];
      end
      b0_q  <= dmag;
      wz0_q <= in_data_i.wz;
    end
  end

  // restoring divide, index 0 is the range check, index j+1 after bit Q_W-1-j
  logic [DIVD_W-1:0] r_q   [Q_W+1][LANES];
  logic [Q_W-1:0]    q_q   [Q_W+1][LANES];
  logic [LANES-1:0]  ovf_q [Q_W+1];
  logic [LANES-1:0]  neg_q [Q_W+1];
  logic [DEN_W-1:0]  b_q   [Q_W+1];
  logic              wz_q  [Q_W+1];

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int l = 0; l < LANES; l++) begin
        r_q[0][l]    <= a0_q[l];
        q_q[0][l]    <= '0;
        ovf_q[0][l]  <= a0_q[l] >= (DIVD_W'(b0_q) << Q_W);
      end
      neg_q[0] <= neg0_q;
      b_q[0]   <= b0_q;
      wz_q[0]  <= wz0_q;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int BIT = Q_W - 1 - j;
    logic [DIVD_W-1:0] t;
    logic [LANES-1:0]  ge;

    always_comb begin
      t = DIVD_W'(b_q[j]) << BIT;
      for (int l = 0; l < LANES; l++) begin
        ge[l] = r_q[j][l] >= t;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[j+2]) begin
        for (int l = 0; l < LANES; l++) begin
          r_q[j+1][l] <= ge[l] ? r_q[j][l] - t : r_q[j][l];
          q_q[j+1][l] <= q_q[j][l] | (ge[l] ? (Q_W'(1) << BIT) : '0);
        end
        ovf_q[j+1] <= ovf_q[j];
        neg_q[j+1] <= neg_q[j];
        b_q[j+1]   <= b_q[j];
        wz_q[j+1]  <= wz_q[j];
      end
    end
  end

  // sign and clamp; a negative result may reach one step further
  function automatic logic signed [PIX_W-1:0] saturate(
    input logic [Q_W-1:0] q,
    input logic           ovf,
    input logic           neg
  );
    logic signed [PIX_W-1:0] res;
    if (!neg) begin
      res = (ovf || q[Q_W-1]) ? PIX_MAX : PIX_W'(q);
    end else if (ovf || (q[Q_W-1] && |q[Q_W-2:0])) begin
      res = PIX_MIN;
    end else begin
      res = PIX_W'(0) - PIX_W'(q);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ld[STAGES-1]) begin
      out_data_o.screen_x   <= saturate(q_q[Q_W][0], ovf_q[Q_W][0], neg_q[Q_W][0]);
      out_data_o.screen_y   <= saturate(q_q[Q_W][1], ovf_q[Q_W][1], neg_q[Q_W][1]);
      out_data_o.w_was_zero <= wz_q[Q_W];
    end
  end

endmodule

`default_nettype wire

### rtl/vertex_rotate_project_viewport_top.sv
// Perspective vertex transform: each beat on vertex_i carries one model vertex
// (Q4.12 x, y, z); each beat on pixel_o carries its 12-bit signed viewport
// position and a flag set when w was zero and 1.0 stood in for it. The
// vertex is rotated about Z then X (Q2.14 cos/sin registers), pushed 3.0 into
// the screen, scaled by the projection registers, divided by w and mapped as
// (p + 1) * size / 2 with truncation toward zero and saturation. Throughput is
// one vertex per clock while the output is not stalled; the path is 22
// register stages, 7 for the transform front end and 15 for the divider,
// which resolves one quotient bit per stage. Beats never get lost under
// back-pressure; empty stages close up, so input keeps flowing while a result
// waits until the whole pipeline is full. Registers are written through the
// cfg port and should only change while no vertex is in flight.
`default_nettype none

module vertex_rotate_project_viewport_top
  import vrpv_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  vrpv_stream_if.sink           vertex_i,
  vrpv_stream_if.source         pixel_o
);

  // 1.0 in Q2.14 for the cosines, 1.0 in Q4.12 for the scales
  localparam cfg_t CFG_RESET = '{
    cos_z:         16'sd16384,
    sin_z:         16'sd0,
    cos_x:         16'sd16384,
    sin_x:         16'sd0,
    proj_x_scale:  16'd4096,
    proj_y_scale:  16'd4096,
    screen_width:  11'd300,
    screen_height: 11'd300
  };

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_COS_Z:         cfg_q.cos_z         <= cfg_wdata_i;
        REG_SIN_Z:         cfg_q.sin_z         <= cfg_wdata_i;
        REG_COS_X:         cfg_q.cos_x         <= cfg_wdata_i;
        REG_SIN_X:         cfg_q.sin_x         <= cfg_wdata_i;
        REG_PROJ_X_SCALE:  cfg_q.proj_x_scale  <= cfg_wdata_i;
        REG_PROJ_Y_SCALE:  cfg_q.proj_y_scale  <= cfg_wdata_i;
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata_i[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: rotation, depth offset, projection scale, viewport size
  logic xf_valid, xf_ready;
  xf_t  xf_data;

  vrpv_xform #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_xform (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i  (vertex_i.valid),
    .in_ready_o  (vertex_i.ready),
    .in_data_i   (vertex_i.data),
    .out_valid_o (xf_valid),
    .out_ready_i (xf_ready),
    .out_data_o  (xf_data)
  );

  // back end: divide by w, sign and clamp; its last stage is the output register
  vrpv_div u_div (
    .clk_i,
    .rst_ni,
    .in_valid_i  (xf_valid),
    .in_ready_o  (xf_ready),
    .in_data_i   (xf_data),
    .out_valid_o (pixel_o.valid),
    .out_ready_i (pixel_o.ready),
    .out_data_o  (pixel_o.data)
  );

endmodule

`default_nettype wire
